FILE: design/gbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gbp_pkg;

    // Default sizes. All three must be powers of two.
    localparam int BTB_ENTRIES_DEF  = 1024;
    localparam int PHT_ENTRIES_DEF  = 256;
    localparam int HISTORY_BITS_DEF = 8;

    // Words held between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    localparam int ADDR_W = 64;

    // One accepted word after classification.
    typedef struct packed {
        logic              upd;     // update with a resolved branch
        logic              cond;    // update of a conditional branch: train the counter
        logic              taken;   // resolved direction
        logic [ADDR_W-1:0] pc;
        logic [ADDR_W-1:0] target;
    } item_t;

    // Queue head as seen by the back.
    typedef struct packed {
        logic  valid;
        item_t item;
    } front_out_t;

    // Control from the back to the front.
    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctrl_t;

    // One branch target buffer entry.
    typedef struct packed {
        logic              valid;
        logic              cond;
        logic [ADDR_W-1:0] tag;
        logic [ADDR_W-1:0] dest;
    } btb_line_t;

endpackage

`default_nettype wire

FILE: design/gshare_btb_branch_predictor_top.sv
// A predict word goes from the queue through the idle and execute states to the done register.
// The back engine takes a new word only after its read-then-write pass on the last one.
// A two-word queue lets start be taken while the back engine still works on an earlier word.
// After reset, busy stays high while the sweep clears max(BTB_ENTRIES, PHT_ENTRIES) addresses.
// Results are never held off: done marks each one for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module gshare_btb_branch_predictor_top #(
    parameter int BTB_ENTRIES  = gbp_pkg::BTB_ENTRIES_DEF,
    parameter int PHT_ENTRIES  = gbp_pkg::PHT_ENTRIES_DEF,
    parameter int HISTORY_BITS = gbp_pkg::HISTORY_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        func,
    input  wire logic [gbp_pkg::ADDR_W-1:0]  pc,
    input  wire logic                        is_cond,
    input  wire logic                        was_taken,
    input  wire logic [gbp_pkg::ADDR_W-1:0]  branch_target,
    output logic [gbp_pkg::ADDR_W-1:0]       next_pc,
    output logic                             pred_taken,
    output logic                             done
);

    // The block has two halves. The front takes a word whenever start is high and
    // busy is low, tags it as a predict, an unconditional update or a conditional
    // update, and drops it into a short queue. The back engine pulls one word at a
    // time from that queue and works on it in its idle and execute states.
    //
    // As the idle state pops a word, the branch target buffer and pattern table
    // are read. The buffer index is taken from the address bits just above the
    // instruction alignment, and the counter index is the same address bits XOR
    // the global history. In the execute state a predict word compares the full
    // stored tag with its address and forms the result, while an update word
    // rewrites the buffer entry and, for a conditional branch, writes back the
    // trained counter and shifts the resolved direction into the history.
    //
    // Both tables live in synchronous RAMs. Since the buffer holds its valid bit
    // inside each RAM word, reset starts a sweep that writes zero to every entry
    // of both RAMs. The front reports busy during the sweep, so no word enters
    // before the tables hold their reset contents.
    //
    // The table sizes must be powers of two.

    gbp_pkg::front_out_t head;
    gbp_pkg::back_ctrl_t ctrl;

    gbp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .pc            (pc),
        .is_cond       (is_cond),
        .was_taken     (was_taken),
        .branch_target (branch_target),
        .ctrl          (ctrl),
        .head          (head)
    );

    gbp_back #(
        .BTB_ENTRIES  (BTB_ENTRIES),
        .PHT_ENTRIES  (PHT_ENTRIES),
        .HISTORY_BITS (HISTORY_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .ctrl       (ctrl),
        .next_pc    (next_pc),
        .pred_taken (pred_taken),
        .done       (done)
    );

endmodule

`default_nettype wire

FILE: design/gbp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module gbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/gbp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module gbp_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        func,
    input  wire logic [gbp_pkg::ADDR_W-1:0]  pc,
    input  wire logic                        is_cond,
    input  wire logic                        was_taken,
    input  wire logic [gbp_pkg::ADDR_W-1:0]  branch_target,
    input  wire gbp_pkg::back_ctrl_t         ctrl,
    output gbp_pkg::front_out_t              head
);

    localparam int QD  = gbp_pkg::QUEUE_DEPTH;
    localparam int QAW = (QD > 1) ? $clog2(QD) : 1;

    gbp_pkg::item_t q_reg [QD];
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW:0]   count_reg, count_next;

    gbp_pkg::item_t new_item;
    logic           push;
    logic           pop;

    // Predicts use only the address; updates mark whether the counter trains.
    always_comb
    begin
        new_item.upd    = func;
        new_item.cond   = func & is_cond;
        new_item.taken  = was_taken;
        new_item.pc     = pc;
        new_item.target = branch_target;
    end

    assign busy = ctrl.clearing || (count_reg == (QAW+1)'(QD));
    assign push = start && !busy;
    assign pop  = ctrl.pop;

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QD-1)) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QD-1)) ? '0 : rd_ptr_reg + QAW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (QAW+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QAW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = q_reg[rd_ptr_reg];

endmodule

`default_nettype wire

FILE: design/gbp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module gbp_back #(
    parameter int BTB_ENTRIES  = gbp_pkg::BTB_ENTRIES_DEF,
    parameter int PHT_ENTRIES  = gbp_pkg::PHT_ENTRIES_DEF,
    parameter int HISTORY_BITS = gbp_pkg::HISTORY_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire gbp_pkg::front_out_t         head,
    output gbp_pkg::back_ctrl_t              ctrl,
    output logic [gbp_pkg::ADDR_W-1:0]       next_pc,
    output logic                             pred_taken,
    output logic                             done
);

    localparam int AW        = gbp_pkg::ADDR_W;
    localparam int BW        = $clog2(BTB_ENTRIES);
    localparam int PW        = $clog2(PHT_ENTRIES);
    localparam int XW        = (HISTORY_BITS > PW) ? HISTORY_BITS : PW;
    localparam int CLR_DEPTH = (BTB_ENTRIES > PHT_ENTRIES) ? BTB_ENTRIES : PHT_ENTRIES;
    localparam int CW        = $clog2(CLR_DEPTH);
    localparam int EW        = $bits(gbp_pkg::btb_line_t);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [CW-1:0]           clr_cnt_reg, clr_cnt_next;
    logic [HISTORY_BITS-1:0] hist_reg, hist_next;
    logic                    done_reg, done_next;

    gbp_pkg::item_t          cur_reg, cur_next;
    logic [AW-1:0]           fall_reg, fall_next;
    logic [PW-1:0]           pidx_reg, pidx_next;
    logic [AW-1:0]           next_pc_reg, next_pc_next;
    logic                    taken_reg, taken_next;

    logic                    btb_we;
    logic [BW-1:0]           btb_waddr;
    gbp_pkg::btb_line_t      btb_wdata;
    logic [BW-1:0]           btb_raddr;
    logic [EW-1:0]           btb_rdata;
    gbp_pkg::btb_line_t      btb_entry;

    logic                    pht_we;
    logic [PW-1:0]           pht_waddr;
    logic [1:0]              pht_wdata;
    logic [PW-1:0]           pht_raddr;
    logic [1:0]              pht_rdata;

    logic [XW-1:0]           hist_x;
    logic [PW-1:0]           head_pidx;
    logic                    clr_pht_ok;
    logic                    hit;
    logic                    predict_taken;
    logic [1:0]              ctr_trained;

    gbp_ram #(
        .WIDTH (EW),
        .DEPTH (BTB_ENTRIES)
    ) u_btb_ram (
        .clk   (clk),
        .we    (btb_we),
        .waddr (btb_waddr),
        .wdata (btb_wdata),
        .raddr (btb_raddr),
        .rdata (btb_rdata)
    );

    gbp_ram #(
        .WIDTH (2),
        .DEPTH (PHT_ENTRIES)
    ) u_pht_ram (
        .clk   (clk),
        .we    (pht_we),
        .waddr (pht_waddr),
        .wdata (pht_wdata),
        .raddr (pht_raddr),
        .rdata (pht_rdata)
    );

    // Lookup addresses come straight from the queue head and the current history.
    assign hist_x    = XW'(hist_reg);
    assign head_pidx = head.item.pc[2 +: PW] ^ hist_x[PW-1:0];
    assign btb_raddr = head.item.pc[2 +: BW];
    assign pht_raddr = head_pidx;

    assign btb_entry     = gbp_pkg::btb_line_t'(btb_rdata);
    assign hit           = btb_entry.valid && (btb_entry.tag == cur_reg.pc);
    assign predict_taken = hit && (!btb_entry.cond || pht_rdata[1]);
    assign clr_pht_ok    = ({1'b0, clr_cnt_reg} < (CW+1)'(PHT_ENTRIES));

    always_comb
    begin
        if (cur_reg.taken)
        begin
            ctr_trained = (pht_rdata == 2'd3) ? 2'd3 : pht_rdata + 2'd1;
        end
        else
        begin
            ctr_trained = (pht_rdata == 2'd0) ? 2'd0 : pht_rdata - 2'd1;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        hist_next    = hist_reg;
        done_next    = 1'b0;
        cur_next     = cur_reg;
        fall_next    = fall_reg;
        pidx_next    = pidx_reg;
        next_pc_next = next_pc_reg;
        taken_next   = taken_reg;

        ctrl.pop      = 1'b0;
        ctrl.clearing = 1'b0;

        btb_we    = 1'b0;
        btb_waddr = cur_reg.pc[2 +: BW];
        btb_wdata = '{valid: 1'b1, cond: cur_reg.cond, tag: cur_reg.pc, dest: cur_reg.target};
        pht_we    = 1'b0;
        pht_waddr = pidx_reg;
        pht_wdata = ctr_trained;

        case (state_reg)
            ST_CLEAR:
            begin
                ctrl.clearing = 1'b1;
                btb_we        = ({1'b0, clr_cnt_reg} < (CW+1)'(BTB_ENTRIES));
                btb_waddr     = clr_cnt_reg[BW-1:0];
                btb_wdata     = '0;
                pht_we        = clr_pht_ok;
                pht_waddr     = clr_cnt_reg[PW-1:0];
                pht_wdata     = 2'd0;
                if (clr_cnt_reg == CW'(CLR_DEPTH-1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + CW'(1);
                end
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    ctrl.pop   = 1'b1;
                    cur_next   = head.item;
                    fall_next  = head.item.pc + AW'(4);
                    pidx_next  = head_pidx;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                if (cur_reg.upd)
                begin
                    btb_we = 1'b1;
                    if (cur_reg.cond)
                    begin
                        pht_we    = 1'b1;
                        hist_next = {hist_reg[HISTORY_BITS-2:0], cur_reg.taken};
                    end
                end
                else
                begin
                    done_next    = 1'b1;
                    taken_next   = predict_taken;
                    next_pc_next = predict_taken ? btb_entry.dest : fall_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            hist_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            hist_reg    <= hist_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        fall_reg    <= fall_next;
        pidx_reg    <= pidx_next;
        next_pc_reg <= next_pc_next;
        taken_reg   <= taken_next;
    end

    assign next_pc    = next_pc_reg;
    assign pred_taken = taken_reg;
    assign done       = done_reg;

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int ADDR_W     = gbp_pkg::ADDR_W;
    localparam int BTB_N      = gbp_pkg::BTB_ENTRIES_DEF;
    localparam int PHT_N      = gbp_pkg::PHT_ENTRIES_DEF;
    localparam int HIST_W     = gbp_pkg::HISTORY_BITS_DEF;
    localparam int BTB_IDX_W  = $clog2(BTB_N);
    localparam int PHT_IDX_W  = $clog2(PHT_N);

    localparam int RANDOM_WORDS = 900;
    localparam int POOL_SIZE    = 16;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int TAIL_CYCLES  = 8;

    localparam logic [ADDR_W-1:0] ALL_ONES = '1;
    localparam logic [ADDR_W-1:0] JUMP_DST = 64'hA5A5_0000_0000_1234;
    localparam logic [ADDR_W-1:0] LOOP_DST = 64'h5555_AAAA_5555_AAAA;

    typedef enum logic {
        OP_PREDICT = 1'b0,
        OP_UPDATE  = 1'b1
    } op_t;

    // One word on the command side, with an optional hand-written expectation.
    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] pc;
        logic              cond;
        logic              taken;
        logic [ADDR_W-1:0] target;
        logic              has_exp;
        logic [ADDR_W-1:0] exp_pc;
        logic              exp_taken;
    } branch_word_t;

    typedef struct packed {
        logic [ADDR_W-1:0] next_pc;
        logic              taken;
    } fetch_guess_t;

    // DUT ports
    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              func;
    logic [ADDR_W-1:0] pc;
    logic              is_cond;
    logic              was_taken;
    logic [ADDR_W-1:0] branch_target;
    logic [ADDR_W-1:0] next_pc;
    logic              pred_taken;
    logic              done;

    gshare_btb_branch_predictor_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .pc            (pc),
        .is_cond       (is_cond),
        .was_taken     (was_taken),
        .branch_target (branch_target),
        .next_pc       (next_pc),
        .pred_taken    (pred_taken),
        .done          (done)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Directed words. Expectations are typed in where they follow straight
    // from the rules: the empty tables after reset, the address wrap, and
    // hits on unconditional entries. The rest go through the predictor.
    branch_word_t directed_rows [25] = '{
        // Empty tables: fall through to pc+4.
        '{OP_PREDICT, 64'h0,          1'b0, 1'b0, 64'h0,    1'b1, 64'h4, 1'b0},
        // Fall-through wraps past the top of the address space; the
        // update-only fields are ignored by a predict.
        '{OP_PREDICT, ALL_ONES,       1'b1, 1'b1, ALL_ONES, 1'b1, 64'h3, 1'b0},
        '{OP_PREDICT, ALL_ONES - 3,   1'b1, 1'b0, ALL_ONES, 1'b1, 64'h0, 1'b0},
        // Unconditional branch: hit predicts taken whatever the counter says,
        // and neither the counters nor the history move.
        '{OP_UPDATE,  64'h1000,       1'b0, 1'b0, JUMP_DST, 1'b0, 64'h0, 1'b0},
        '{OP_PREDICT, 64'h1000,       1'b0, 1'b0, 64'h0,    1'b1, JUMP_DST, 1'b1},
        // Same BTB slot, different tag: a miss.
        '{OP_PREDICT, 64'h2000_0000_0000_1000, 1'b0, 1'b0, 64'h0,
          1'b1, 64'h2000_0000_0000_1004, 1'b0},
        '{OP_UPDATE,  ALL_ONES,       1'b0, 1'b1, ALL_ONES, 1'b0, 64'h0, 1'b0},
        '{OP_PREDICT, ALL_ONES,       1'b0, 1'b0, 64'h0,    1'b1, ALL_ONES, 1'b1},
        // Not-taken at zero stays at zero; the history shifts in a zero.
        '{OP_UPDATE,  64'h0,          1'b1, 1'b0, 64'h0,    1'b0, 64'h0, 1'b0},
        '{OP_PREDICT, 64'h0,          1'b0, 1'b0, 64'h0,    1'b1, 64'h4, 1'b0},
        // A taken loop branch: the history fills with ones, after which the
        // same counter is hit again and again and saturates at three.
        '{OP_UPDATE,  64'h40,         1'b1, 1'b1, LOOP_DST, 1'b0, 64'h0, 1'b0},
        '{OP_UPDATE,  64'h40,         1'b1, 1'b1, LOOP_DST, 1'b0, 64'h0, 1'b0},
        '{OP_UPDATE,  64'h40,         1'b1, 1'b1, LOOP_DST, 1'b0, 64'h0, 1'b0},
        '{OP_UPDATE,  64'h40,         1'b1, 1'b1, LOOP_DST, 1'b0, 64'h0, 1'b0},
        '{OP_UPDATE,  64'h40,         1'b1, 1'b1, LOOP_DST, 1'b0, 64'h0, 1'b0},
        '{OP_UPDATE,  64'h40,         1'b1, 1'b1, LOOP_DST, 1'b0, 64'h0, 1'b0},
        '{OP_UPDATE,  64'h40,         1'b1, 1'b1, LOOP_DST, 1'b0, 64'h0, 1'b0},
        '{OP_UPDATE,  64'h40,         1'b1, 1'b1, LOOP_DST, 1'b0, 64'h0, 1'b0},
        '{OP_UPDATE,  64'h40,         1'b1, 1'b1, LOOP_DST, 1'b0, 64'h0, 1'b0},
        '{OP_UPDATE,  64'h40,         1'b1, 1'b1, LOOP_DST, 1'b0, 64'h0, 1'b0},
        '{OP_UPDATE,  64'h40,         1'b1, 1'b1, LOOP_DST, 1'b0, 64'h0, 1'b0},
        '{OP_UPDATE,  64'h40,         1'b1, 1'b1, LOOP_DST, 1'b0, 64'h0, 1'b0},
        '{OP_PREDICT, 64'h40,         1'b0, 1'b0, 64'h0,    1'b0, 64'h0, 1'b0},
        // One not-taken exit moves the history onto a fresh counter.
        '{OP_UPDATE,  64'h40,         1'b1, 1'b0, LOOP_DST, 1'b0, 64'h0, 1'b0},
        '{OP_PREDICT, 64'h40,         1'b0, 1'b0, 64'h0,    1'b0, 64'h0, 1'b0}
    };

    // Predictor state, kept in step with the block at each accepted word.
    logic [HIST_W-1:0]  model_history;
    logic [1:0]         model_counter [PHT_N];
    gbp_pkg::btb_line_t model_btb [BTB_N];

    branch_word_t words [$];
    fetch_guess_t pending_fetch [$];
    int           mismatch_count;
    int           cycle_count;

    function automatic logic [PHT_IDX_W-1:0] counter_slot(logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] hist_wide;
        hist_wide = ADDR_W'(model_history);
        return PHT_IDX_W'((addr >> 2) ^ hist_wide);
    endfunction

    function automatic fetch_guess_t gshare_lookup(logic [ADDR_W-1:0] addr);
        gbp_pkg::btb_line_t e;
        fetch_guess_t       g;
        e = model_btb[addr[BTB_IDX_W+1:2]];
        if (e.valid && e.tag == addr && (!e.cond || model_counter[counter_slot(addr)] >= 2'd2))
        begin
            g.next_pc = e.dest;
            g.taken   = 1'b1;
        end
        else
        begin
            g.next_pc = addr + 64'd4;
            g.taken   = 1'b0;
        end
        return g;
    endfunction

    task automatic gshare_train(branch_word_t w);
        logic [PHT_IDX_W-1:0] slot;
        slot = counter_slot(w.pc);
        model_btb[w.pc[BTB_IDX_W+1:2]] = '{valid: 1'b1, cond: w.cond, tag: w.pc, dest: w.target};
        if (w.cond)
        begin
            if (w.taken && model_counter[slot] != 2'd3)
                model_counter[slot] = model_counter[slot] + 2'd1;
            else if (!w.taken && model_counter[slot] != 2'd0)
                model_counter[slot] = model_counter[slot] - 2'd1;
            model_history = {model_history[HIST_W-2:0], w.taken};
        end
    endtask

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Random words mostly revisit a small set of branches, so entries hit,
    // counters train in both directions and aliases evict each other. A few
    // words are pure noise.
    task automatic build_random_words();
        logic [ADDR_W-1:0] pool_pc   [POOL_SIZE];
        logic [ADDR_W-1:0] pool_dest [POOL_SIZE];
        logic              pool_cond [POOL_SIZE];
        int                pool_bias [POOL_SIZE];
        branch_word_t      w;
        int                k;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_pc[i] = {$urandom, $urandom};
            if ($urandom_range(0, 3) != 0)
                pool_pc[i][1:0] = 2'b00;
            // Some branches share a BTB slot with their neighbor.
            if (i > 0 && $urandom_range(0, 3) == 0)
                pool_pc[i] = pool_pc[i-1] ^ ({$urandom, $urandom} << (BTB_IDX_W + 2));
            pool_dest[i] = {$urandom, $urandom};
            pool_cond[i] = ($urandom_range(0, 4) != 0);
            pool_bias[i] = (i % 4 == 0) ? 100 : (i % 4 == 1) ? 0 : $urandom_range(0, 100);
        end
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            w         = '0;
            w.cond    = 1'($urandom_range(0, 1));
            w.taken   = 1'($urandom_range(0, 1));
            w.target  = {$urandom, $urandom};
            k         = $urandom_range(0, 99);
            if (k < 8)
            begin
                w.op = op_t'($urandom_range(0, 1));
                w.pc = {$urandom, $urandom};
            end
            else
            begin
                k    = $urandom_range(0, POOL_SIZE - 1);
                w.op = ($urandom_range(0, 1) == 0) ? OP_PREDICT : OP_UPDATE;
                w.pc = pool_pc[k];
                if (w.op == OP_UPDATE)
                begin
                    w.cond  = pool_cond[k] ^ ($urandom_range(0, 19) == 0);
                    w.taken = ($urandom_range(1, 100) <= pool_bias[k]);
                    if ($urandom_range(0, 9) != 0)
                        w.target = pool_dest[k];
                end
            end
            words.push_back(w);
        end
    endtask

    task automatic drive_word(branch_word_t w);
        func          <= w.op;
        pc            <= w.pc;
        is_cond       <= w.cond;
        was_taken     <= w.taken;
        branch_target <= w.target;
        start         <= 1'b1;
    endtask

    // Result side: done can not be held off, so every strobe is checked.
    always @(posedge clk)
    begin
        fetch_guess_t want;
        if (rst_n && done)
        begin
            if (pending_fetch.size() == 0)
                report_mismatch($sformatf("result with nothing pending: next_pc=%h taken=%b",
                                          next_pc, pred_taken));
            else
            begin
                want = pending_fetch.pop_front();
                if (next_pc !== want.next_pc)
                    report_mismatch($sformatf("next_pc %h, expected %h", next_pc, want.next_pc));
                if (pred_taken !== want.taken)
                    report_mismatch($sformatf("pred_taken %b, expected %b",
                                              pred_taken, want.taken));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int burst_left;
        int gap;
        int idx;
        branch_word_t w;

        mismatch_count = 0;
        cycle_count    = 0;
        model_history  = '0;
        foreach (model_counter[i])
            model_counter[i] = 2'd0;
        foreach (model_btb[i])
            model_btb[i] = '0;

        rst_n         <= 1'b0;
        start         <= 1'b0;
        func          <= 1'b0;
        pc            <= '0;
        is_cond       <= 1'b0;
        was_taken     <= 1'b0;
        branch_target <= '0;

        foreach (directed_rows[i])
            words.push_back(directed_rows[i]);
        build_random_words();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // The first word waits out the table clear behind busy.
        @(posedge clk);
        idx        = 0;
        burst_left = $urandom_range(1, 20);
        drive_word(words[0]);

        while (idx < words.size())
        begin
            @(posedge clk);
            if (start && !busy)
            begin
                w = words[idx];
                if (w.op == OP_PREDICT)
                begin
                    if (w.has_exp)
                        pending_fetch.push_back('{next_pc: w.exp_pc, taken: w.exp_taken});
                    else
                        pending_fetch.push_back(gshare_lookup(w.pc));
                end
                else
                    gshare_train(w);
                idx++;
                burst_left--;
                if (idx < words.size())
                begin
                    if (burst_left <= 0)
                    begin
                        // Bursts of various lengths; some of the gaps between them land mid-way
                        // through the back engine's read-then-write pass.
                        case ($urandom_range(0, 4))
                            0: gap = 0;
                            1, 2: gap = $urandom_range(1, 3);
                            3: gap = $urandom_range(4, 12);
                            default: gap = $urandom_range(13, 40);
                        endcase
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 12);
                        if (gap > 0)
                        begin
                            start <= 1'b0;
                            repeat (gap) @(posedge clk);
                        end
                    end
                    drive_word(words[idx]);
                end
                else
                    start <= 1'b0;
            end
        end

        while (pending_fetch.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
